// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the I2C register access master RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/i2cram_pkg.sv =====
// Package for the I2C register access master: command, phase and stage
// codes, status codes, register indexes and the structs passed between modules.
package i2cram_pkg;

  localparam int CFG_DATA_W = 8;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACK_POLL_LIMIT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_READ_RETRY_LIMIT = 2'd2;

  localparam logic [6:0] RST_DEVICE_ADDRESS = 7'd72;
  localparam logic [7:0] RST_ACK_POLL_LIMIT = 8'd10;
  localparam logic [4:0] RST_READ_RETRY_LIMIT = 5'd20;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_ADDR_NACK = 2'd1;
  localparam logic [1:0] STATUS_PTR_NACK = 2'd2;
  localparam logic [1:0] STATUS_RETRY_OUT = 2'd3;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_WRITE,
    CMD_READ
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START_FALL,
    PH_START_LOW,
    PH_RS_REL,
    PH_RS_HIGH,
    PH_TX_LOW,
    PH_TX_HIGH,
    PH_ACK_LOW,
    PH_ACK_HIGH,
    PH_RX_LOW,
    PH_RX_HIGH,
    PH_MA_LOW,
    PH_MA_HIGH,
    PH_STOP1,
    PH_STOP2,
    PH_STOP3
  } phase_t;

  typedef enum logic [2:0] {
    SG_WADDR,
    SG_PTR,
    SG_DHI,
    SG_DLO,
    SG_RADDR,
    SG_RHI,
    SG_RLO
  } stage_t;

  typedef struct packed {
    logic [6:0] device_address;
    logic [7:0] ack_poll_limit;
    logic [4:0] read_retry_limit;
  } cfg_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  reg_addr;
    logic [15:0] write_data;
    logic        sda_in;
  } item_t;

endpackage

// ===== hdl/i2cram_front.sv =====
// Front end: configuration registers and request classification.
// Depends on i2cram_pkg.
module i2cram_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [i2cram_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [i2cram_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [1:0]                          kind,
  input  logic [7:0]                          reg_addr,
  input  logic [15:0]                         write_data,
  input  logic                                sda_in,
  output i2cram_pkg::item_t                   item,
  output i2cram_pkg::cfg_t                    cfg
);

  i2cram_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address <= i2cram_pkg::RST_DEVICE_ADDRESS;
      cfg.ack_poll_limit <= i2cram_pkg::RST_ACK_POLL_LIMIT;
      cfg.read_retry_limit <= i2cram_pkg::RST_READ_RETRY_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        i2cram_pkg::CFG_DEVICE_ADDRESS: cfg.device_address <= cfg_data[6:0];
        i2cram_pkg::CFG_ACK_POLL_LIMIT: cfg.ack_poll_limit <= cfg_data[7:0];
        i2cram_pkg::CFG_READ_RETRY_LIMIT: cfg.read_retry_limit <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (kind)
      i2cram_pkg::KIND_WRITE: cmd = i2cram_pkg::CMD_WRITE;
      i2cram_pkg::KIND_READ: cmd = i2cram_pkg::CMD_READ;
      default: cmd = i2cram_pkg::CMD_TICK;
    endcase
  end

  assign item.cmd = cmd;
  assign item.reg_addr = reg_addr;
  assign item.write_data = write_data;
  assign item.sda_in = sda_in;

endmodule

// ===== hdl/i2cram_queue.sv =====
// Request queue between the front end and the bus engine.
// Depends on i2cram_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2cram_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  i2cram_pkg::item_t push_item,
  output logic              full,
  input  logic              pop,
  output i2cram_pkg::item_t pop_item,
  output logic              not_empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  i2cram_pkg::item_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push = push && !full;
  assign do_pop = pop && not_empty;
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(DEPTH), "queue count over depth")
  `ASSERT_NEXT(a_count_up, do_push && !do_pop, count == $past(count) + CNT_W'(1), "queue count lost a push")
  `ASSERT_IMPLY(a_ptr_match, count == '0 || count == CNT_W'(DEPTH), wr_ptr == rd_ptr, "queue pointers out of step")

endmodule

// ===== hdl/i2cram_engine.sv =====
// Bus engine: steps the I2C line phase sequence once per request and
// registers the result. Depends on i2cram_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2cram_engine (
  input  logic              clk,
  input  logic              rst,
  input  i2cram_pkg::cfg_t  cfg,
  input  i2cram_pkg::item_t item,
  input  logic              item_valid,
  output logic              item_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              scl_out,
  output logic              sda_pull_low,
  output logic              busy_res,
  output logic              done_res,
  output logic [1:0]        status,
  output logic [15:0]       read_value
);

  i2cram_pkg::phase_t phase, phase_next, ph;
  i2cram_pkg::stage_t stage, stage_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [7:0]  ack_wait, ack_wait_next;
  logic [4:0]  retry_count, retry_count_next;
  logic [15:0] captured, captured_next;
  logic        is_read, is_read_next;
  logic [7:0]  held_pointer, held_pointer_next;
  logic [15:0] held_write, held_write_next;
  logic [1:0]  pending, pending_next;
  logic [7:0]  ack_lim;
  logic [4:0]  retry_lim;
  logic        scl_c, pull_c, busy_c, done_c;
  logic [1:0]  stat_c;
  logic        advance;

  assign advance = item_valid && (!out_valid || !out_stall);
  assign item_pop = advance;
  assign ack_lim = (cfg.ack_poll_limit == 8'd0) ? 8'd1 : cfg.ack_poll_limit;
  assign retry_lim = (cfg.read_retry_limit == 5'd0) ? 5'd1 : cfg.read_retry_limit;

  always_comb begin
    stage_next = stage;
    bit_index_next = bit_index;
    shift_byte_next = shift_byte;
    ack_wait_next = ack_wait;
    retry_count_next = retry_count;
    captured_next = captured;
    is_read_next = is_read;
    held_pointer_next = held_pointer;
    held_write_next = held_write;
    pending_next = pending;
    scl_c = 1'b1;
    pull_c = 1'b0;
    busy_c = 1'b1;
    done_c = 1'b0;
    stat_c = i2cram_pkg::STATUS_OK;
    ph = phase;

    if (phase == i2cram_pkg::PH_IDLE && item.cmd != i2cram_pkg::CMD_TICK) begin
      is_read_next = (item.cmd == i2cram_pkg::CMD_READ);
      held_pointer_next = item.reg_addr;
      held_write_next = item.write_data;
      stage_next = i2cram_pkg::SG_WADDR;
      pending_next = i2cram_pkg::STATUS_OK;
      retry_count_next = 5'd0;
      ack_wait_next = 8'd0;
      ph = i2cram_pkg::PH_START_FALL;
    end

    phase_next = ph;

    case (ph)
      i2cram_pkg::PH_START_FALL: begin
        pull_c = 1'b1;
        phase_next = i2cram_pkg::PH_START_LOW;
      end
      i2cram_pkg::PH_START_LOW: begin
        scl_c = 1'b0;
        pull_c = 1'b1;
        shift_byte_next = {cfg.device_address, stage_next == i2cram_pkg::SG_RADDR};
        bit_index_next = 4'd0;
        phase_next = i2cram_pkg::PH_TX_LOW;
      end
      i2cram_pkg::PH_RS_REL: begin
        scl_c = 1'b0;
        phase_next = i2cram_pkg::PH_RS_HIGH;
      end
      i2cram_pkg::PH_RS_HIGH: begin
        phase_next = i2cram_pkg::PH_START_FALL;
      end
      i2cram_pkg::PH_TX_LOW: begin
        scl_c = 1'b0;
        pull_c = !shift_byte_next[7];
        phase_next = i2cram_pkg::PH_TX_HIGH;
      end
      i2cram_pkg::PH_TX_HIGH: begin
        pull_c = !shift_byte_next[7];
        shift_byte_next = {shift_byte_next[6:0], 1'b0};
        bit_index_next = bit_index_next + 4'd1;
        if (bit_index_next >= 4'd8) begin
          ack_wait_next = 8'd0;
          phase_next = i2cram_pkg::PH_ACK_LOW;
        end else begin
          phase_next = i2cram_pkg::PH_TX_LOW;
        end
      end
      i2cram_pkg::PH_ACK_LOW: begin
        scl_c = 1'b0;
        phase_next = i2cram_pkg::PH_ACK_HIGH;
      end
      i2cram_pkg::PH_ACK_HIGH: begin
        if (stage_next == i2cram_pkg::SG_DHI || stage_next == i2cram_pkg::SG_DLO ||
            !item.sda_in) begin
          case (stage_next)
            i2cram_pkg::SG_WADDR: begin
              stage_next = i2cram_pkg::SG_PTR;
              shift_byte_next = held_pointer_next;
              bit_index_next = 4'd0;
              phase_next = i2cram_pkg::PH_TX_LOW;
            end
            i2cram_pkg::SG_PTR: begin
              if (is_read_next) begin
                stage_next = i2cram_pkg::SG_RADDR;
                retry_count_next = 5'd1;
                phase_next = i2cram_pkg::PH_RS_REL;
              end else begin
                stage_next = i2cram_pkg::SG_DHI;
                shift_byte_next = held_write_next[15:8];
                bit_index_next = 4'd0;
                phase_next = i2cram_pkg::PH_TX_LOW;
              end
            end
            i2cram_pkg::SG_DHI: begin
              stage_next = i2cram_pkg::SG_DLO;
              shift_byte_next = held_write_next[7:0];
              bit_index_next = 4'd0;
              phase_next = i2cram_pkg::PH_TX_LOW;
            end
            i2cram_pkg::SG_DLO: begin
              pending_next = i2cram_pkg::STATUS_OK;
              phase_next = i2cram_pkg::PH_STOP1;
            end
            default: begin
              stage_next = i2cram_pkg::SG_RHI;
              bit_index_next = 4'd0;
              phase_next = i2cram_pkg::PH_RX_LOW;
            end
          endcase
        end else begin
          ack_wait_next = ack_wait_next + 8'd1;
          if (ack_wait_next >= ack_lim) begin
            if (stage_next == i2cram_pkg::SG_WADDR) begin
              pending_next = i2cram_pkg::STATUS_ADDR_NACK;
            end else if (stage_next == i2cram_pkg::SG_PTR) begin
              pending_next = i2cram_pkg::STATUS_PTR_NACK;
            end
            phase_next = i2cram_pkg::PH_STOP1;
          end
        end
      end
      i2cram_pkg::PH_RX_LOW: begin
        scl_c = 1'b0;
        phase_next = i2cram_pkg::PH_RX_HIGH;
      end
      i2cram_pkg::PH_RX_HIGH: begin
        captured_next = {captured_next[14:0], item.sda_in};
        bit_index_next = bit_index_next + 4'd1;
        phase_next = (bit_index_next >= 4'd8) ? i2cram_pkg::PH_MA_LOW : i2cram_pkg::PH_RX_LOW;
      end
      i2cram_pkg::PH_MA_LOW: begin
        scl_c = 1'b0;
        pull_c = (stage_next == i2cram_pkg::SG_RHI);
        phase_next = i2cram_pkg::PH_MA_HIGH;
      end
      i2cram_pkg::PH_MA_HIGH: begin
        pull_c = (stage_next == i2cram_pkg::SG_RHI);
        if (stage_next == i2cram_pkg::SG_RHI) begin
          stage_next = i2cram_pkg::SG_RLO;
          bit_index_next = 4'd0;
          phase_next = i2cram_pkg::PH_RX_LOW;
        end else begin
          pending_next = i2cram_pkg::STATUS_OK;
          phase_next = i2cram_pkg::PH_STOP1;
        end
      end
      i2cram_pkg::PH_STOP1: begin
        scl_c = 1'b0;
        pull_c = 1'b1;
        phase_next = i2cram_pkg::PH_STOP2;
      end
      i2cram_pkg::PH_STOP2: begin
        pull_c = 1'b1;
        phase_next = i2cram_pkg::PH_STOP3;
      end
      i2cram_pkg::PH_STOP3: begin
        if (stage_next == i2cram_pkg::SG_RADDR) begin
          if (retry_count_next >= retry_lim) begin
            done_c = 1'b1;
            stat_c = i2cram_pkg::STATUS_RETRY_OUT;
            phase_next = i2cram_pkg::PH_IDLE;
          end else begin
            retry_count_next = retry_count_next + 5'd1;
            phase_next = i2cram_pkg::PH_START_FALL;
          end
        end else begin
          done_c = 1'b1;
          stat_c = pending_next;
          phase_next = i2cram_pkg::PH_IDLE;
        end
      end
      default: begin
        busy_c = 1'b0;
        phase_next = i2cram_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= i2cram_pkg::PH_IDLE;
      stage <= i2cram_pkg::SG_WADDR;
      bit_index <= 4'd0;
      shift_byte <= 8'd0;
      ack_wait <= 8'd0;
      retry_count <= 5'd0;
      captured <= 16'd0;
      is_read <= 1'b0;
      held_pointer <= 8'd0;
      held_write <= 16'd0;
      pending <= i2cram_pkg::STATUS_OK;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        phase <= phase_next;
        stage <= stage_next;
        bit_index <= bit_index_next;
        shift_byte <= shift_byte_next;
        ack_wait <= ack_wait_next;
        retry_count <= retry_count_next;
        captured <= captured_next;
        is_read <= is_read_next;
        held_pointer <= held_pointer_next;
        held_write <= held_write_next;
        pending <= pending_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      scl_out <= scl_c;
      sda_pull_low <= pull_c;
      busy_res <= busy_c;
      done_res <= done_c;
      status <= stat_c;
      read_value <= captured_next;
    end
  end

  `ASSERT_IMPLY(a_status_on_done, out_valid && status != i2cram_pkg::STATUS_OK, done_res && busy_res, "error status without done")
  `ASSERT_NEXT(a_done_to_idle, advance && done_c, phase == i2cram_pkg::PH_IDLE, "done without return to idle")
  `ASSERT_IMPLY(a_idle_lines, out_valid && !busy_res, scl_out && !sda_pull_low && !done_res, "idle tick drove the bus")

endmodule

// ===== hdl/i2c_register_access_master.sv =====
// Top level of the I2C register access master: front end, request queue
// and bus engine. Depends on i2cram_pkg, i2cram_front, i2cram_queue, i2cram_engine.
//
// Each request is one bus tick and returns exactly one result. A request can be
// taken every clock cycle while in_stall is low: the front end classifies it
// into a QUEUE_DEPTH-entry queue, and the bus engine steps its phase state
// machine by one tick per cycle, unless out_stall holds it, into an output
// register. With no stall, a request passes through the queue and then the
// output register; in_stall rises only when the queue is full, which happens
// only while out_stall holds the output register. Configuration is written
// through cfg_valid/cfg_ready, always ready, and applies even mid-command.
module i2c_register_access_master #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          kind,
  input  logic [7:0]                          reg_addr,
  input  logic [15:0]                         write_data,
  input  logic                                sda_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                scl_out,
  output logic                                sda_pull_low,
  output logic                                busy_res,
  output logic                                done_res,
  output logic [1:0]                          status,
  output logic [15:0]                         read_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [i2cram_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [i2cram_pkg::CFG_DATA_W-1:0]   cfg_data
);

  i2cram_pkg::item_t front_item;
  i2cram_pkg::item_t queue_item;
  i2cram_pkg::cfg_t  cfg;
  logic              queue_full;
  logic              queue_not_empty;
  logic              queue_pop;

  assign in_stall = queue_full;

  i2cram_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .kind       (kind),
    .reg_addr   (reg_addr),
    .write_data (write_data),
    .sda_in     (sda_in),
    .item       (front_item),
    .cfg        (cfg)
  );

  i2cram_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_item (front_item),
    .full      (queue_full),
    .pop       (queue_pop),
    .pop_item  (queue_item),
    .not_empty (queue_not_empty)
  );

  i2cram_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item         (queue_item),
    .item_valid   (queue_not_empty),
    .item_pop     (queue_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .scl_out      (scl_out),
    .sda_pull_low (sda_pull_low),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .status       (status),
    .read_value   (read_value)
  );

endmodule

// ===== dv/tb_i2c_register_access_master.sv =====
// Self-checking testbench for i2c_register_access_master: drives bus ticks and
// register accesses, predicts every line phase, status and read value, and checks them.
// Depends on i2cram_pkg and the i2c_register_access_master RTL.
module tb_i2c_register_access_master;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 64;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic        scl;
    logic        pull;
    logic        busy;
    logic        done;
    logic [1:0]  st;
    logic [15:0] rdata;
  } line_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] kind = i2cram_pkg::KIND_TICK;
  logic [7:0] reg_addr = '0;
  logic [15:0] write_data = '0;
  logic sda_in = 1'b1;
  logic out_valid;
  logic out_stall = 1'b0;
  logic scl_out;
  logic sda_pull_low;
  logic busy_res;
  logic done_res;
  logic [1:0] status;
  logic [15:0] read_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [i2cram_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [i2cram_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // bus model state
  logic [6:0] dev_addr = i2cram_pkg::RST_DEVICE_ADDRESS;
  logic [7:0] poll_lim = i2cram_pkg::RST_ACK_POLL_LIMIT;
  logic [4:0] retry_lim = i2cram_pkg::RST_READ_RETRY_LIMIT;
  i2cram_pkg::phase_t bus_phase = i2cram_pkg::PH_IDLE;
  i2cram_pkg::stage_t bus_stage = i2cram_pkg::SG_WADDR;
  logic [3:0] bit_cnt = '0;
  logic [7:0] tx_byte = '0;
  logic [7:0] poll_cnt = '0;
  logic [4:0] attempt_cnt = '0;
  logic [15:0] rx_word = '0;
  logic rd_cmd = 1'b0;
  logic [7:0] ptr_hold = '0;
  logic [15:0] wr_hold = '0;
  logic [1:0] end_code = i2cram_pkg::STATUS_OK;

  line_result_t line_q[$];
  int n_err = 0;
  int n_ticks = 0;
  int n_cmds = 0;
  int n_reads = 0;
  int n_settings = 0;
  int n_cycles = 0;
  int done_seen[4] = '{0, 0, 0, 0};
  int snd_pct = 0;
  int rcv_pct = 0;
  int hold_cnt = 0;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;

  i2c_register_access_master uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .reg_addr(reg_addr), .write_data(write_data), .sda_in(sda_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .scl_out(scl_out), .sda_pull_low(sda_pull_low), .busy_res(busy_res),
    .done_res(done_res), .status(status), .read_value(read_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic void load_tx(input logic [7:0] b);
    tx_byte = b;
    bit_cnt = '0;
    bus_phase = i2cram_pkg::PH_TX_LOW;
  endfunction

  function automatic line_result_t step_bus(input logic [1:0] k, input logic [7:0] ra,
                                            input logic [15:0] wd, input logic sda);
    line_result_t r;
    logic [7:0] poll_max;
    logic [4:0] try_max;
    r = '0;
    r.scl = 1'b1;
    r.busy = 1'b1;
    r.st = i2cram_pkg::STATUS_OK;
    poll_max = (poll_lim == 8'd0) ? 8'd1 : poll_lim;
    try_max = (retry_lim == 5'd0) ? 5'd1 : retry_lim;
    if (bus_phase == i2cram_pkg::PH_IDLE &&
        (k == i2cram_pkg::KIND_WRITE || k == i2cram_pkg::KIND_READ)) begin
      rd_cmd = (k == i2cram_pkg::KIND_READ);
      ptr_hold = ra;
      wr_hold = wd;
      bus_stage = i2cram_pkg::SG_WADDR;
      end_code = i2cram_pkg::STATUS_OK;
      attempt_cnt = '0;
      poll_cnt = '0;
      bus_phase = i2cram_pkg::PH_START_FALL;
    end
    case (bus_phase)
      i2cram_pkg::PH_START_FALL: begin
        r.pull = 1'b1;
        bus_phase = i2cram_pkg::PH_START_LOW;
      end
      i2cram_pkg::PH_START_LOW: begin
        r.scl = 1'b0;
        r.pull = 1'b1;
        load_tx({dev_addr, bus_stage == i2cram_pkg::SG_RADDR});
      end
      i2cram_pkg::PH_RS_REL: begin
        r.scl = 1'b0;
        bus_phase = i2cram_pkg::PH_RS_HIGH;
      end
      i2cram_pkg::PH_RS_HIGH: bus_phase = i2cram_pkg::PH_START_FALL;
      i2cram_pkg::PH_TX_LOW: begin
        r.scl = 1'b0;
        r.pull = ~tx_byte[7];
        bus_phase = i2cram_pkg::PH_TX_HIGH;
      end
      i2cram_pkg::PH_TX_HIGH: begin
        r.pull = ~tx_byte[7];
        tx_byte = tx_byte << 1;
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 4'd8) begin
          poll_cnt = '0;
          bus_phase = i2cram_pkg::PH_ACK_LOW;
        end else begin
          bus_phase = i2cram_pkg::PH_TX_LOW;
        end
      end
      i2cram_pkg::PH_ACK_LOW: begin
        r.scl = 1'b0;
        bus_phase = i2cram_pkg::PH_ACK_HIGH;
      end
      i2cram_pkg::PH_ACK_HIGH: begin
        if (bus_stage == i2cram_pkg::SG_DHI || bus_stage == i2cram_pkg::SG_DLO || !sda) begin
          case (bus_stage)
            i2cram_pkg::SG_WADDR: begin
              bus_stage = i2cram_pkg::SG_PTR;
              load_tx(ptr_hold);
            end
            i2cram_pkg::SG_PTR: begin
              if (rd_cmd) begin
                bus_stage = i2cram_pkg::SG_RADDR;
                attempt_cnt = 5'd1;
                bus_phase = i2cram_pkg::PH_RS_REL;
              end else begin
                bus_stage = i2cram_pkg::SG_DHI;
                load_tx(wr_hold[15:8]);
              end
            end
            i2cram_pkg::SG_DHI: begin
              bus_stage = i2cram_pkg::SG_DLO;
              load_tx(wr_hold[7:0]);
            end
            i2cram_pkg::SG_DLO: begin
              end_code = i2cram_pkg::STATUS_OK;
              bus_phase = i2cram_pkg::PH_STOP1;
            end
            default: begin
              bus_stage = i2cram_pkg::SG_RHI;
              bit_cnt = '0;
              bus_phase = i2cram_pkg::PH_RX_LOW;
            end
          endcase
        end else begin
          poll_cnt = poll_cnt + 8'd1;
          if (poll_cnt >= poll_max) begin
            if (bus_stage == i2cram_pkg::SG_WADDR) end_code = i2cram_pkg::STATUS_ADDR_NACK;
            else if (bus_stage == i2cram_pkg::SG_PTR) end_code = i2cram_pkg::STATUS_PTR_NACK;
            bus_phase = i2cram_pkg::PH_STOP1;
          end
        end
      end
      i2cram_pkg::PH_RX_LOW: begin
        r.scl = 1'b0;
        bus_phase = i2cram_pkg::PH_RX_HIGH;
      end
      i2cram_pkg::PH_RX_HIGH: begin
        rx_word = {rx_word[14:0], sda};
        bit_cnt = bit_cnt + 4'd1;
        bus_phase = (bit_cnt >= 4'd8) ? i2cram_pkg::PH_MA_LOW : i2cram_pkg::PH_RX_LOW;
      end
      i2cram_pkg::PH_MA_LOW: begin
        r.scl = 1'b0;
        r.pull = (bus_stage == i2cram_pkg::SG_RHI);
        bus_phase = i2cram_pkg::PH_MA_HIGH;
      end
      i2cram_pkg::PH_MA_HIGH: begin
        r.pull = (bus_stage == i2cram_pkg::SG_RHI);
        if (bus_stage == i2cram_pkg::SG_RHI) begin
          bus_stage = i2cram_pkg::SG_RLO;
          bit_cnt = '0;
          bus_phase = i2cram_pkg::PH_RX_LOW;
        end else begin
          end_code = i2cram_pkg::STATUS_OK;
          bus_phase = i2cram_pkg::PH_STOP1;
        end
      end
      i2cram_pkg::PH_STOP1: begin
        r.scl = 1'b0;
        r.pull = 1'b1;
        bus_phase = i2cram_pkg::PH_STOP2;
      end
      i2cram_pkg::PH_STOP2: begin
        r.pull = 1'b1;
        bus_phase = i2cram_pkg::PH_STOP3;
      end
      i2cram_pkg::PH_STOP3: begin
        if (bus_stage == i2cram_pkg::SG_RADDR && attempt_cnt < try_max) begin
          attempt_cnt = attempt_cnt + 5'd1;
          bus_phase = i2cram_pkg::PH_START_FALL;
        end else begin
          r.done = 1'b1;
          r.st = (bus_stage == i2cram_pkg::SG_RADDR) ? i2cram_pkg::STATUS_RETRY_OUT : end_code;
          bus_phase = i2cram_pkg::PH_IDLE;
        end
      end
      default: begin
        r.busy = 1'b0;
        bus_phase = i2cram_pkg::PH_IDLE;
      end
    endcase
    r.rdata = rx_word;
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_err++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    line_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (line_q.size() == 0) begin
        $error("bus tick result with no request outstanding");
        n_err++;
      end else begin
        want = line_q.pop_front();
        check_field("scl_out", want.scl, scl_out);
        check_field("sda_pull_low", want.pull, sda_pull_low);
        check_field("busy_res", want.busy, busy_res);
        check_field("done_res", want.done, done_res);
        check_field("status", want.st, status);
        check_field("read_value", want.rdata, read_value);
        if (want.done) done_seen[want.st]++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req != hold_ack) begin
      out_stall <= 1'b1;
      hold_ack <= hold_req;
      hold_cnt <= HOLD_CYCLES;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_pct);
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_tick(input logic [1:0] k, input logic [7:0] ra,
                           input logic [15:0] wd, input logic sda);
    in_valid <= 1'b1;
    kind <= k;
    reg_addr <= ra;
    write_data <= wd;
    sda_in <= sda;
    do @(posedge clk); while (in_stall);
    line_q.push_back(step_bus(k, ra, wd, sda));
    n_ticks++;
    if ($urandom_range(0, 99) < snd_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_pct);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (line_q.size() != 0);
  endtask

  task automatic write_reg(input logic [i2cram_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [i2cram_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      i2cram_pkg::CFG_DEVICE_ADDRESS: dev_addr = val[6:0];
      i2cram_pkg::CFG_ACK_POLL_LIMIT: poll_lim = val;
      i2cram_pkg::CFG_READ_RETRY_LIMIT: retry_lim = val[4:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] dev, input logic [7:0] poll,
                                input logic [7:0] tries);
    drain();
    write_reg(i2cram_pkg::CFG_DEVICE_ADDRESS, dev);
    write_reg(i2cram_pkg::CFG_ACK_POLL_LIMIT, poll);
    write_reg(i2cram_pkg::CFG_READ_RETRY_LIMIT, tries);
    n_settings++;
  endtask

  // nw/np/nr: percent chance the target leaves SDA high on an address, pointer
  // or read-address ack poll
  task automatic run_cmd(input logic [1:0] k, input logic [7:0] ra, input logic [15:0] wd,
                         input logic [15:0] rx, input int nw, input int np, input int nr);
    int pct;
    int rx_bit;
    logic sda;
    logic [1:0] bk;
    rx_bit = 15;
    n_cmds++;
    if (k == i2cram_pkg::KIND_READ) n_reads++;
    send_tick(k, ra, wd, 1'($urandom_range(0, 1)));
    while (bus_phase != i2cram_pkg::PH_IDLE) begin
      sda = 1'($urandom_range(0, 1));
      if (bus_phase == i2cram_pkg::PH_ACK_HIGH) begin
        case (bus_stage)
          i2cram_pkg::SG_WADDR: pct = nw;
          i2cram_pkg::SG_PTR: pct = np;
          i2cram_pkg::SG_RADDR: pct = nr;
          default: pct = 50;
        endcase
        sda = ($urandom_range(0, 99) < pct);
      end else if (bus_phase == i2cram_pkg::PH_RX_HIGH) begin
        sda = rx[rx_bit];
        rx_bit = (rx_bit == 0) ? 15 : rx_bit - 1;
      end
      bk = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : i2cram_pkg::KIND_TICK;
      send_tick(bk, 8'($urandom), 16'($urandom), sda);
    end
  endtask

  function automatic int pick_nack();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 7) return 30;
    return (poll_lim <= 8'd8 && retry_lim <= 5'd8) ? 100 : 50;
  endfunction

  task automatic test_reset_defaults();
    send_tick(i2cram_pkg::KIND_TICK, 8'h00, 16'h0000, 1'b0);
    send_tick(KIND_SPARE, 8'hFF, 16'hFFFF, 1'b1);
    run_cmd(i2cram_pkg::KIND_WRITE, 8'h00, 16'hFFFF, 16'h0000, 0, 0, 0);
    run_cmd(i2cram_pkg::KIND_WRITE, 8'hFF, 16'h0000, 16'hFFFF, 0, 0, 0);
    run_cmd(i2cram_pkg::KIND_READ, 8'hA5, 16'h0000, 16'hFFFF, 0, 0, 0);
    run_cmd(i2cram_pkg::KIND_READ, 8'h5A, 16'hFFFF, 16'h0000, 0, 0, 0);
    run_cmd(i2cram_pkg::KIND_READ, 8'h81, 16'h1234, 16'hC3A5, 0, 0, 40);
    send_tick(KIND_SPARE, 8'h00, 16'h0000, 1'b0);
  endtask

  task automatic test_ack_failures();
    apply_settings(8'h00, 8'd2, 8'd3);
    run_cmd(i2cram_pkg::KIND_WRITE, 8'h11, 16'hBEEF, 16'h0000, 100, 0, 0);
    run_cmd(i2cram_pkg::KIND_WRITE, 8'h22, 16'hCAFE, 16'h0000, 0, 100, 0);
    run_cmd(i2cram_pkg::KIND_READ, 8'h33, 16'h0000, 16'h0F0F, 100, 0, 0);
    run_cmd(i2cram_pkg::KIND_READ, 8'h44, 16'h0000, 16'hF0F0, 0, 100, 0);
    run_cmd(i2cram_pkg::KIND_READ, 8'h55, 16'h0000, 16'h1357, 0, 0, 100);
    run_cmd(i2cram_pkg::KIND_READ, 8'h66, 16'h0000, 16'h2468, 0, 0, 60);
  endtask

  task automatic test_zero_limits();
    apply_settings(8'hFF, 8'd0, 8'd0);
    run_cmd(i2cram_pkg::KIND_READ, 8'h77, 16'h0000, 16'h0000, 0, 0, 100);
    run_cmd(i2cram_pkg::KIND_WRITE, 8'h88, 16'h5555, 16'h0000, 100, 0, 0);
    run_cmd(i2cram_pkg::KIND_READ, 8'h99, 16'h0000, 16'hAAAA, 0, 0, 0);
  endtask

  task automatic test_backpressure();
    snd_pct = 0;
    rcv_pct <= 0;
    hold_req <= ~hold_req;
    run_cmd(i2cram_pkg::KIND_READ, 8'h3C, 16'h0000, 16'h8001, 0, 0, 0);
    drain();
    run_cmd(i2cram_pkg::KIND_WRITE, 8'hC3, 16'h1234, 16'h0000, 0, 0, 0);
    drain();
  endtask

  task automatic test_random_traffic();
    int goal;
    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin
          snd_pct = 21;
          rcv_pct <= 69;
          apply_settings(8'(i2cram_pkg::RST_DEVICE_ADDRESS), i2cram_pkg::RST_ACK_POLL_LIMIT,
                         8'(i2cram_pkg::RST_READ_RETRY_LIMIT));
        end
        1: begin
          snd_pct = 69;
          rcv_pct <= 21;
          apply_settings(8'd127, 8'd255, 8'd31);
        end
        default: begin
          snd_pct = 0;
          rcv_pct <= 0;
          apply_settings(8'($urandom), 8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)));
        end
      endcase
      goal = n_ticks + 40;
      while (n_ticks < goal) begin
        repeat ($urandom_range(0, 3))
          send_tick($urandom_range(0, 1) ? i2cram_pkg::KIND_TICK : KIND_SPARE, 8'($urandom),
                    16'($urandom), 1'($urandom));
        if (m == 2 && $urandom_range(0, 9) == 0)
          apply_settings(8'($urandom), 8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)));
        run_cmd(2'($urandom_range(1, 2)), 8'($urandom), 16'($urandom), 16'($urandom),
                pick_nack(), pick_nack(), pick_nack());
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_ack_failures();
    test_zero_limits();
    test_backpressure();
    test_random_traffic();
    drain();
    repeat (8) @(posedge clk);
    $display("Ran %0d bus ticks: %0d register accesses (%0d reads) over %0d register settings",
             n_ticks, n_cmds, n_reads, n_settings);
    $display("Completions: ok %0d, address nack %0d, pointer nack %0d, retries exhausted %0d",
             done_seen[0], done_seen[1], done_seen[2], done_seen[3]);
    if (n_err == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/i2cram_pkg.sv
hdl/i2cram_front.sv
hdl/i2cram_queue.sv
hdl/i2cram_engine.sv
hdl/i2c_register_access_master.sv
dv/tb_i2c_register_access_master.sv
